// ===== rtl/dfdu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dfdu_pkg;

  // Panel geometry
  localparam int COLUMNS = 128;
  localparam int PAGES   = 16;

  // Frame store geometry
  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Max commands caused by one frame byte
  localparam int MAX_CMDS = 3;

  // Command kinds
  typedef enum logic [1:0] {
    KIND_PAGE   = 2'd0,
    KIND_COLUMN = 2'd1,
    KIND_DATA   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } cmd_t;

  // Commands of one byte, handed from generator to output sequencer
  typedef struct packed {
    cmd_t [MAX_CMDS-1:0] cmd;
    logic [1:0]          count;
  } batch_t;

endpackage

`default_nettype wire

// ===== rtl/dfdu_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Frame byte channel
interface dfdu_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] page;
  logic [6:0] column;
  logic [7:0] pixels;
  logic       redraw;

  modport source (output valid, page, column, pixels, redraw, input ready);
  modport sink (input valid, page, column, pixels, redraw, output ready);
endinterface

// Panel command channel
interface dfdu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, kind, value, last, input ready);
  modport sink (input valid, kind, value, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/dfdu_frame_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfdu_frame_ram
  import dfdu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]             rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  output logic                   busy
);

  logic [7:0]        mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  // Clearing sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Single write port, shared by the sweep
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 8'd0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dfdu_cmd_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfdu_cmd_gen
  import dfdu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  dfdu_in_if.sink           frame_in,
  input  wire logic         clear_busy,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  wire logic [7:0]   rd_data,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output batch_t            batch,
  output logic              batch_valid,
  input  wire logic         seq_free
);

  // Byte held while its prior value comes out of the store
  logic              s1_valid;
  logic [3:0]        s1_page;
  logic [6:0]        s1_col;
  logic [7:0]        s1_pix;
  logic              s1_redraw;
  logic              s1_inrange;
  logic [ADDR_W-1:0] s1_idx;
  logic              fwd_hit;
  logic [7:0]        fwd_data;

  // Panel tracking state
  logic [6:0] panel_column;
  logic       full_mode;

  logic              acc;
  logic              s1_go;
  logic              in_range;
  logic [ADDR_W-1:0] idx_in;
  logic [7:0]        prior;
  logic              fstart;
  logic              fend;
  logic              fm;
  logic              changed;
  logic [6:0]        col_inc;
  logic [6:0]        panel_column_next;
  logic [1:0]        n;

  assign in_range = (32'(frame_in.page) < 32'(PAGES)) &&
                    (32'(frame_in.column) < 32'(COLUMNS));
  assign idx_in   = ADDR_W'(32'(frame_in.page) * 32'(COLUMNS) + 32'(frame_in.column));

  assign s1_go          = s1_valid && ((batch.count == 2'd0) || seq_free);
  assign frame_in.ready = !clear_busy && (!s1_valid || s1_go);
  assign acc            = frame_in.valid && frame_in.ready;

  // Store access: read at accept, write back when the byte leaves
  assign rd_en   = acc && in_range;
  assign rd_addr = idx_in;
  assign wr_en   = s1_go && s1_inrange;
  assign wr_addr = s1_idx;
  assign wr_data = s1_pix;

  assign prior = fwd_hit ? fwd_data : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture byte; forward a write back to the same entry
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_page    <= frame_in.page;
      s1_col     <= frame_in.column;
      s1_pix     <= frame_in.pixels;
      s1_redraw  <= frame_in.redraw;
      s1_inrange <= in_range;
      s1_idx     <= idx_in;
      fwd_hit    <= wr_en && (wr_addr == idx_in);
      fwd_data   <= s1_pix;
    end
  end

  // Command list for the held byte
  always_comb begin
    batch             = '0;
    n                 = 2'd0;
    fstart            = (s1_page == 4'd0) && (s1_col == 7'd0);
    fend              = (32'(s1_page) == 32'(PAGES - 1)) &&
                        (32'(s1_col) == 32'(COLUMNS - 1));
    fm                = fstart ? s1_redraw : full_mode;
    changed           = prior != s1_pix;
    col_inc           = (32'(s1_col) == 32'(COLUMNS - 1)) ? 7'd0 : s1_col + 7'd1;
    panel_column_next = panel_column;
    if (s1_inrange) begin
      if (fstart && s1_redraw) begin
        batch.cmd[n].kind  = KIND_COLUMN;
        batch.cmd[n].value = 8'd0;
        n                  = n + 2'd1;
      end
      if (s1_col == 7'd0) begin
        batch.cmd[n].kind  = KIND_PAGE;
        batch.cmd[n].value = {4'd0, s1_page};
        n                  = n + 2'd1;
      end
      if (fm) begin
        batch.cmd[n].kind  = KIND_DATA;
        batch.cmd[n].value = s1_pix;
        n                  = n + 2'd1;
        panel_column_next  = col_inc;
      end else begin
        if (changed) begin
          if (s1_col != panel_column) begin
            batch.cmd[n].kind  = KIND_COLUMN;
            batch.cmd[n].value = {1'b0, s1_col};
            n                  = n + 2'd1;
          end
          batch.cmd[n].kind  = KIND_DATA;
          batch.cmd[n].value = s1_pix;
          n                  = n + 2'd1;
          panel_column_next  = col_inc;
        end
        // Frame end: park the column pointer at zero
        if (fend) begin
          batch.cmd[n].kind  = KIND_COLUMN;
          batch.cmd[n].value = 8'd0;
          n                  = n + 2'd1;
          panel_column_next  = 7'd0;
        end
      end
    end
    batch.count = n;
  end

  assign batch_valid = s1_go && (batch.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_column <= 7'd0;
      full_mode    <= 1'b0;
    end else if (s1_go && s1_inrange) begin
      panel_column <= panel_column_next;
      full_mode    <= fm;
    end
  end

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !s1_valid)
    else $error("item held during store clearing");

  a_column_range: assert property (@(posedge clk) disable iff (rst)
    32'(panel_column) < 32'(COLUMNS))
    else $error("panel column out of range");

endmodule

`default_nettype wire

// ===== rtl/dfdu_out_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfdu_out_seq
  import dfdu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire batch_t batch,
  input  wire logic   batch_valid,
  output logic        seq_free,
  dfdu_out_if.source  cmd_out
);

  logic                seq_valid;
  cmd_t [MAX_CMDS-1:0] cmds;
  logic [1:0]          cnt;
  logic [1:0]          idx;
  logic                at_last;

  assign at_last  = idx == (cnt - 2'd1);
  assign seq_free = !seq_valid || (cmd_out.ready && at_last);

  // Step through the held commands, one per cycle while cmd_out.ready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (seq_free) begin
      seq_valid <= batch_valid;
      idx       <= 2'd0;
    end else if (cmd_out.ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_free && batch_valid) begin
      cmds <= batch.cmd;
      cnt  <= batch.count;
    end
  end

  assign cmd_out.valid = seq_valid;
  assign cmd_out.kind  = cmds[idx].kind;
  assign cmd_out.value = cmds[idx].value;
  assign cmd_out.last  = at_last;

  a_idx_in_list: assert property (@(posedge clk) disable iff (rst)
    seq_valid |-> (cnt != 2'd0) && (idx < cnt))
    else $error("command index beyond list");

  a_idx_holds: assert property (@(posedge clk) disable iff (rst)
    seq_valid && !cmd_out.ready |=> seq_valid && $stable(idx))
    else $error("command index moved while stalled");

endmodule

`default_nettype wire

// ===== rtl/display_frame_diff_updater_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Payload                          Notes
// frame_in   in   page, column, pixels, redraw     one frame byte per item
// cmd_out    out  kind, value, last                one panel command per item
//
// An item producing k commands (k = 1..3) holds the command port until all k
// have gone out; items with one command stream at one per cycle while cmd_out
// is ready, and items with no command at one per cycle. A byte and its store
// read are registered together; its commands are registered again in the
// output sequencer. After reset a clearing pass over all PAGES*COLUMNS = 2048
// entries zeroes the frame store; frame_in.ready stays low until it ends.
// A stall on cmd_out backs up into frame_in.ready combinationally.

module display_frame_diff_updater_unit
  import dfdu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  dfdu_in_if.sink    frame_in,
  dfdu_out_if.source cmd_out
);

  logic              clear_busy;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  batch_t            batch;
  logic              batch_valid;
  logic              seq_free;

  dfdu_frame_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .busy    (clear_busy)
  );

  dfdu_cmd_gen u_gen (
    .clk         (clk),
    .rst         (rst),
    .frame_in    (frame_in),
    .clear_busy  (clear_busy),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .batch       (batch),
    .batch_valid (batch_valid),
    .seq_free    (seq_free)
  );

  dfdu_out_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .batch       (batch),
    .batch_valid (batch_valid),
    .seq_free    (seq_free),
    .cmd_out     (cmd_out)
  );

endmodule

`default_nettype wire

// ===== verif/dfdu_cmd_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts the panel commands of every accepted frame
// byte and compares each accepted command against the oldest prediction.
module dfdu_cmd_checker
  import dfdu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dfdu_in_if   frame_in,
  dfdu_out_if  cmd_out,
  output int   pending,
  output int   fails,
  output int   checked
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } panel_cmd_t;

  // Predicted panel state
  logic [7:0] prior_bytes [DEPTH];
  logic [6:0] panel_col;
  logic       full_mode;

  panel_cmd_t expected_cmds [$];
  int         n_fails;
  int         n_checked;

  function automatic panel_cmd_t make_cmd(input kind_t k, input logic [7:0] v);
    panel_cmd_t c;
    c.kind  = k;
    c.value = v;
    c.last  = 1'b0;
    return c;
  endfunction

  // Commands caused by one frame byte, appended to the expected queue
  task automatic predict_commands(input logic [3:0] pg, input logic [6:0] col,
                                  input logic [7:0] pix, input logic rd);
    panel_cmd_t burst [$];
    int         addr;
    if (int'(pg) >= PAGES || int'(col) >= COLUMNS) return;
    addr = int'(pg) * COLUMNS + int'(col);

    // first byte of a frame picks the mode for the whole frame
    if (pg == 4'd0 && col == 7'd0) begin
      full_mode = rd;
      if (full_mode) begin
        burst.push_back(make_cmd(KIND_COLUMN, 8'd0));
        panel_col = '0;
      end
    end
    if (col == 7'd0) burst.push_back(make_cmd(KIND_PAGE, 8'(pg)));

    if (full_mode) begin
      burst.push_back(make_cmd(KIND_DATA, pix));
      panel_col = 7'((int'(col) + 1) % COLUMNS);
    end else begin
      // changed bytes only; reposition when the pointer is elsewhere
      if (prior_bytes[addr] != pix) begin
        if (col != panel_col) burst.push_back(make_cmd(KIND_COLUMN, 8'(col)));
        burst.push_back(make_cmd(KIND_DATA, pix));
        panel_col = 7'((int'(col) + 1) % COLUMNS);
      end
      // last byte of the frame parks the pointer at column 0
      if (int'(pg) == PAGES - 1 && int'(col) == COLUMNS - 1) begin
        burst.push_back(make_cmd(KIND_COLUMN, 8'd0));
        panel_col = '0;
      end
    end

    prior_bytes[addr] = pix;
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) expected_cmds.push_back(burst[i]);
  endtask

  // Predict on input items, compare on output items
  always @(posedge clk) begin
    panel_cmd_t want;
    if (rst) begin
      foreach (prior_bytes[i]) prior_bytes[i] = 8'h00;
      expected_cmds.delete();
      panel_col = '0;
      full_mode = 1'b0;
      n_fails   = 0;
      n_checked = 0;
    end else begin
      if (frame_in.valid && frame_in.ready)
        predict_commands(frame_in.page, frame_in.column, frame_in.pixels, frame_in.redraw);

      if (cmd_out.valid && cmd_out.ready) begin
        n_checked++;
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected command: expected none, actual kind=%0d value=%0d last=%0d",
                   $time, cmd_out.kind, cmd_out.value, cmd_out.last);
          n_fails++;
        end else begin
          want = expected_cmds.pop_front();
          if (cmd_out.kind !== want.kind || cmd_out.value !== want.value ||
              cmd_out.last !== want.last) begin
            $display("%0t: command mismatch: expected kind=%0d value=%0d last=%0d, actual kind=%0d value=%0d last=%0d",
                     $time, want.kind, want.value, want.last,
                     cmd_out.kind, cmd_out.value, cmd_out.last);
            n_fails++;
          end
        end
      end
    end
    pending <= expected_cmds.size();
    fails   <= n_fails;
    checked <= n_checked;
  end

endmodule

// ===== verif/display_frame_diff_updater_unit_tb.sv =====
`timescale 1ns / 1ps

module display_frame_diff_updater_unit_tb;
  import dfdu_pkg::*;

  localparam int TOTAL_ITEMS  = 352;
  localparam int PAUSE_AT     = 120;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 150;
  localparam int STEADY_FROM  = 250;
  localparam int STEADY_TO    = 320;
  localparam int IDLE_PCT     = 16;
  localparam int END_SETTLE   = 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst;

  dfdu_in_if  frame_in ();
  dfdu_out_if cmd_out ();

  int pending;
  int fails;
  int checked;

  int items_sent;
  int frame_starts;
  int redraw_starts;
  int cycle_count;
  bit hold_done;

  // last pixels handed in per byte, so repeats can be sent on purpose
  logic [7:0] last_pixels [DEPTH];

  wire steady_window = (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);

  display_frame_diff_updater_unit dut (
    .clk      (clk),
    .rst      (rst),
    .frame_in (frame_in),
    .cmd_out  (cmd_out)
  );

  dfdu_cmd_checker cmd_check (
    .clk      (clk),
    .rst      (rst),
    .frame_in (frame_in),
    .cmd_out  (cmd_out),
    .pending  (pending),
    .fails    (fails),
    .checked  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one frame byte after random idle cycles outside the steady window; return once accepted
  task automatic send_byte(input logic [3:0] pg, input logic [6:0] col,
                           input logic [7:0] pix, input logic rd);
    while (!steady_window && $urandom_range(0, 99) < IDLE_PCT) begin
      frame_in.valid <= 1'b0;
      @(posedge clk);
    end
    frame_in.valid  <= 1'b1;
    frame_in.page   <= pg;
    frame_in.column <= col;
    frame_in.pixels <= pix;
    frame_in.redraw <= rd;
    @(posedge clk);
    while (!frame_in.ready) @(posedge clk);
    last_pixels[{pg, col}] = pix;
    items_sent++;
    if (pg == 4'd0 && col == 7'd0) begin
      frame_starts++;
      if (rd) redraw_starts++;
    end
  endtask

  // Mostly repeats and extremes so both changed and unchanged bytes occur
  function automatic logic [7:0] pick_pixels(input logic [3:0] pg, input logic [6:0] col);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return last_pixels[{pg, col}];
    if (roll < 50) return 8'h00;
    if (roll < 55) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Consecutive bytes in frame order, stopping after the frame's last byte
  task automatic send_run(input logic [3:0] pg, input logic [6:0] col, input int len);
    logic [3:0] p;
    logic [6:0] c;
    p = pg;
    c = col;
    for (int k = 0; k < len; k++) begin
      send_byte(p, c, pick_pixels(p, c), 1'($urandom));
      if (c == 7'(COLUMNS - 1)) begin
        if (p == 4'(PAGES - 1)) return;
        p = p + 4'd1;
      end
      c = c + 7'd1;
    end
  endtask

  // Stop offering until every predicted command has come out
  task automatic wait_drained();
    frame_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Command receiver: random stalls, one long hold-off, one steady stretch
  initial begin
    cmd_out.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          cmd_out.ready <= 1'b0;
          @(posedge clk);
        end
        hold_done = 1'b1;
      end else begin
        cmd_out.ready <= steady_window || ($urandom_range(0, 99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  // Cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d commands outstanding", cycle_count, pending);
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int  roll;
    bit  paused;
    paused          = 1'b0;
    items_sent      = 0;
    frame_starts    = 0;
    redraw_starts   = 0;
    hold_done       = 1'b0;
    foreach (last_pixels[i]) last_pixels[i] = 8'h00;
    rst             = 1'b1;
    frame_in.valid  = 1'b0;
    frame_in.page   = '0;
    frame_in.column = '0;
    frame_in.pixels = '0;
    frame_in.redraw = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: difference mode from the cleared store
    send_byte(4'd0,  7'd0,   8'h00, 1'b0);  // frame start, unchanged: page select only
    send_byte(4'd0,  7'd1,   8'hFF, 1'b0);  // jump: column select then data
    send_byte(4'd0,  7'd2,   8'h80, 1'b0);  // consecutive: data only
    send_byte(4'd0,  7'd2,   8'h80, 1'b0);  // unchanged: nothing
    send_byte(4'd3,  7'd0,   8'h01, 1'b0);  // page start plus column select and data
    send_byte(4'd5,  7'd127, 8'hAA, 1'b0);  // last column, pointer wraps
    send_byte(4'd6,  7'd0,   8'h55, 1'b0);  // page start right after the wrap
    send_byte(4'd15, 7'd127, 8'h00, 1'b0);  // frame end, unchanged
    send_byte(4'd15, 7'd127, 8'h3C, 1'b0);  // frame end, changed: three commands
    // directed: full redraw
    send_byte(4'd0,  7'd0,   8'h00, 1'b1);
    send_byte(4'd0,  7'd1,   8'hFF, 1'b1);
    send_byte(4'd7,  7'd0,   8'h00, 1'b0);
    send_byte(4'd9,  7'd64,  8'h00, 1'b0);
    send_byte(4'd15, 7'd127, 8'hFF, 1'b0);  // no parking in full mode
    // directed: back to difference mode; redraw away from frame start is ignored
    send_byte(4'd0,  7'd0,   8'hFF, 1'b0);
    send_byte(4'd0,  7'd5,   8'hFF, 1'b1);
    send_byte(4'd15, 7'd0,   8'h7E, 1'b0);
    send_byte(4'd15, 7'd126, 8'h00, 1'b0);
    send_byte(4'd15, 7'd127, 8'hFF, 1'b0);
    wait_drained();

    // random: mostly runs in frame order, some frame starts/ends, some noise
    while (items_sent < TOTAL_ITEMS) begin
      if (!paused && items_sent >= PAUSE_AT) begin
        wait_drained();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        send_run(4'd0, 7'd0, $urandom_range(1, 12));
      end else if (roll < 27) begin
        send_run(4'(PAGES - 1), 7'(COLUMNS - 1) - 7'($urandom_range(0, 6)), 8);
      end else if (roll < 85) begin
        send_run(4'($urandom_range(0, PAGES - 1)),
                 ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(0, COLUMNS - 1)),
                 $urandom_range(1, 16));
      end else begin
        send_byte(4'($urandom), 7'($urandom), 8'($urandom), 1'($urandom));
      end
    end

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);

    $display("Sent %0d frame bytes (%0d frame starts, %0d with redraw), checked %0d commands",
             items_sent, frame_starts, redraw_starts, checked);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dfdu_pkg.sv
rtl/dfdu_ifs.sv
rtl/dfdu_frame_ram.sv
rtl/dfdu_cmd_gen.sv
rtl/dfdu_out_seq.sv
rtl/display_frame_diff_updater_unit.sv
verif/dfdu_cmd_checker.sv
verif/display_frame_diff_updater_unit_tb.sv
